/* src/zefd_pkg.sv */
package zefd_pkg;

    // Frame layout
    localparam int FRAME_BITS = 19;
    localparam int POS_W      = 5;
    localparam logic [POS_W-1:0] POS_MAX   = 5'd31;
    localparam logic [POS_W-1:0] POS_FRAME = 5'(FRAME_BITS);
    localparam int HI_LSB     = 11;
    localparam int LO_LSB     = 1;

    // Register widths and reset values
    localparam int GAP_W    = 16;
    localparam int MARGIN_W = 8;
    localparam int STROBE_W = 16;
    localparam int TIME_W   = 32;
    localparam int VALUE_W  = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [GAP_W-1:0]    GAP_RESET    = 16'd500;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 8'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_GAP     = 1'b0,
        CFG_STROBE_MARGIN = 1'b1
    } cfg_index_t;

    typedef enum logic {
        OP_EDGE      = 1'b0,
        OP_POWER_OFF = 1'b1
    } opcode_t;

    typedef enum logic {
        ST_VALUE  = 1'b0,
        ST_PARITY = 1'b1
    } status_t;

    // One edge word after the input register
    typedef struct packed {
        logic              opcode;
        logic [TIME_W-1:0] edge_time_us;
        logic              line_level;
    } item_t;

    // Result of one decode step
    typedef struct packed {
        logic               valid;
        logic               status;
        logic [VALUE_W-1:0] sensor_value;
    } result_t;

endpackage

/* src/zefd_core.sv */
module zefd_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                fire,
    input  zefd_pkg::item_t                     item,
    input  logic [zefd_pkg::GAP_W-1:0]          start_gap_us,
    input  logic [zefd_pkg::MARGIN_W-1:0]       strobe_margin_us,
    output zefd_pkg::result_t                   result
);
    import zefd_pkg::*;

    logic [TIME_W-1:0]     last_fall_reg, last_fall_next;
    logic                  waiting_reg, waiting_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [STROBE_W-1:0]   strobe_reg, strobe_next;
    logic [FRAME_BITS-1:0] shift_reg, shift_next;
    logic                  parity_reg, parity_next;
    logic [VALUE_W-1:0]    last_value_reg, last_value_next;
    logic                  have_value_reg, have_value_next;

    logic [TIME_W-1:0]     diff;
    logic [TIME_W-2:0]     half;
    logic                  bit_in;
    logic [FRAME_BITS-1:0] shifted;
    logic [VALUE_W-1:0]    value;

    // Time since last falling edge, modulo 2^32
    assign diff    = item.edge_time_us - last_fall_reg;
    assign half    = diff[TIME_W-1:1];
    assign bit_in  = (diff < TIME_W'(strobe_reg));
    assign shifted = {shift_reg[FRAME_BITS-2:0], bit_in};
    assign value   = {shifted[HI_LSB+7:HI_LSB], shifted[LO_LSB+7:LO_LSB]};

    // Decode step
    always_comb
    begin
        last_fall_next  = last_fall_reg;
        waiting_next    = waiting_reg;
        pos_next        = pos_reg;
        strobe_next     = strobe_reg;
        shift_next      = shift_reg;
        parity_next     = parity_reg;
        last_value_next = last_value_reg;
        have_value_next = have_value_reg;
        result          = '0;

        if (fire)
        begin
            if (item.opcode == OP_POWER_OFF)
            begin
                have_value_next = 1'b0;
            end
            else if (item.line_level)
            begin
                // rising edge: sample one bit
                if (!waiting_reg && pos_reg != '0)
                begin
                    shift_next  = shifted;
                    parity_next = parity_reg ^ bit_in;
                    if (pos_reg == POS_FRAME)
                    begin
                        waiting_next = 1'b1;
                        if (parity_next == 1'b0)
                        begin
                            if (value != last_value_reg || !have_value_reg)
                            begin
                                last_value_next     = value;
                                have_value_next     = 1'b1;
                                result.valid        = 1'b1;
                                result.status       = ST_VALUE;
                                result.sensor_value = value;
                            end
                        end
                        else
                        begin
                            result.valid        = 1'b1;
                            result.status       = ST_PARITY;
                            result.sensor_value = '0;
                        end
                    end
                end
            end
            else
            begin
                // falling edge: frame start or bit boundary
                if (diff > TIME_W'(start_gap_us))
                begin
                    waiting_next = 1'b0;
                    pos_next     = '0;
                end
                else
                begin
                    if (!waiting_reg && pos_reg == '0)
                    begin
                        if (half > (TIME_W-1)'(strobe_margin_us))
                            strobe_next = STROBE_W'(half - (TIME_W-1)'(strobe_margin_us));
                        else
                            strobe_next = '0;
                        shift_next  = '0;
                        parity_next = 1'b0;
                    end
                    if (waiting_reg)
                    begin
                        waiting_next = 1'b0;
                        pos_next     = '0;
                    end
                    else if (pos_reg < POS_MAX)
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
                last_fall_next = item.edge_time_us;
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_fall_reg  <= '0;
            waiting_reg    <= 1'b1;
            pos_reg        <= '0;
            strobe_reg     <= '0;
            shift_reg      <= '0;
            parity_reg     <= 1'b0;
            last_value_reg <= '0;
            have_value_reg <= 1'b0;
        end
        else
        begin
            last_fall_reg  <= last_fall_next;
            waiting_reg    <= waiting_next;
            pos_reg        <= pos_next;
            strobe_reg     <= strobe_next;
            shift_reg      <= shift_next;
            parity_reg     <= parity_next;
            last_value_reg <= last_value_next;
            have_value_reg <= have_value_next;
        end
    end

endmodule

/* src/zacwire_edge_frame_decoder.sv */
// Single-wire duty-cycle frame decoder.
// A taken edge word is held in the input register, then one decode step writes its
// result into a two-word output queue, whose head drives the output.
// Throughput: one edge word per cycle while the output side keeps up.
// Reset (rst_n low, async): waits for a frame start, no value held,
// start gap 500 us, strobe margin 10 us.
module zacwire_edge_frame_decoder (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  opcode,
    input  logic [zefd_pkg::TIME_W-1:0]           edge_time_us,
    input  logic                                  line_level,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  status,
    output logic [zefd_pkg::VALUE_W-1:0]          sensor_value,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [zefd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [zefd_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import zefd_pkg::*;

    typedef struct packed {
        logic               status;
        logic [VALUE_W-1:0] sensor_value;
    } out_word_t;

    logic [GAP_W-1:0]    gap_reg;
    logic [MARGIN_W-1:0] margin_reg;
    logic                s_valid_reg;
    item_t               s_item_reg;
    logic                fire;
    result_t             res;
    out_word_t           q_reg [2];
    logic [1:0]          q_cnt_reg;
    logic                push;
    logic                pop;
    logic [1:0]          q_cnt_mid;
    out_word_t           push_word;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg    <= GAP_RESET;
            margin_reg <= MARGIN_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_START_GAP:     gap_reg    <= cfg_data[GAP_W-1:0];
                CFG_STROBE_MARGIN: margin_reg <= cfg_data[MARGIN_W-1:0];
                default:           ;
            endcase
        end
    end

    // Input register; decode fires when the queue has room
    assign fire     = s_valid_reg && (q_cnt_reg != 2'd2);
    assign in_ready = !s_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_valid_reg <= 1'b0;
        else if (in_ready)
            s_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s_item_reg <= '{opcode: opcode, edge_time_us: edge_time_us,
                            line_level: line_level};
    end

    zefd_core u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .fire             (fire),
        .item             (s_item_reg),
        .start_gap_us     (gap_reg),
        .strobe_margin_us (margin_reg),
        .result           (res)
    );

    // Two-word output queue
    assign push      = res.valid;
    assign pop       = out_valid && out_ready;
    assign q_cnt_mid = q_cnt_reg - {1'b0, pop};
    assign push_word = '{status: res.status, sensor_value: res.sensor_value};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_cnt_reg <= '0;
        else
            q_cnt_reg <= q_cnt_mid + {1'b0, push};
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            q_reg[0] <= q_reg[1];
        if (push)
        begin
            if (q_cnt_mid == 2'd0)
                q_reg[0] <= push_word;
            else
                q_reg[1] <= push_word;
        end
    end

    assign out_valid    = (q_cnt_reg != 2'd0);
    assign status       = q_reg[0].status;
    assign sensor_value = q_reg[0].sensor_value;

endmodule

/* verif/tb_zacwire_edge_frame_decoder.sv */
module tb_zacwire_edge_frame_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import zefd_pkg::*;

    localparam int CLK_HALF_NS  = 4;
    localparam int RESET_CYCLES = 4;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_WORDS  = 225;
    localparam int HOLD_PHASE   = 1;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int WATCHDOG_NS  = 2000000;
    localparam int POS_CEIL     = 31;

    // Where a directed row takes its expectation from
    typedef enum logic [1:0] {
        RC_MODEL,
        RC_NONE,
        RC_PARITY
    } row_check_t;

    typedef struct {
        opcode_t     op;
        logic [31:0] t;
        logic        lvl;
        int          reps;
        logic [31:0] step;
        row_check_t  chk;
    } edge_row_t;

    typedef struct {
        status_t            st;
        logic [VALUE_W-1:0] val;
    } frame_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  opcode = 1'b0;
    logic [TIME_W-1:0]     edge_time_us = '0;
    logic                  line_level = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  status;
    logic [VALUE_W-1:0]    sensor_value;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    zacwire_edge_frame_decoder u_dut (.*);

    always #(CLK_HALF_NS) clk = ~clk;

    // Decoder copy kept by the bench
    logic [TIME_W-1:0]   fall_t = '0;
    int                  pos = -1;
    logic [STROBE_W-1:0] strobe = '0;
    logic [18:0]         shreg = '0;
    logic                par = 1'b0;
    logic [VALUE_W-1:0]  held_val = '0;
    logic                held = 1'b0;
    logic [GAP_W-1:0]    gap_cfg = GAP_RESET;
    logic [MARGIN_W-1:0] margin_cfg = MARGIN_RESET;

    frame_result_t due_results[$];
    edge_row_t     edge_rows[$];

    logic [TIME_W-1:0]  now_us = '0;
    logic [VALUE_W-1:0] last_sent_val = '0;
    bit                 idle_on = 1'b1;
    bit                 hold_req = 1'b0;
    int unsigned        words_sent = 0;
    int unsigned        results_seen = 0;
    int unsigned        parity_seen = 0;
    int unsigned        settings_written = 0;
    int unsigned        mismatches = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // One edge word through the decoder copy; returns 1 when a result is due
    function automatic bit decode_edge(input opcode_t op, input logic [31:0] t,
                                       input logic lvl, output status_t st,
                                       output logic [VALUE_W-1:0] val);
        logic [31:0] dt;
        logic [30:0] half;
        dt  = t - fall_t;
        st  = ST_VALUE;
        val = '0;
        if (op == OP_POWER_OFF)
        begin
            held = 1'b0;
            return 1'b0;
        end
        if (lvl)
        begin
            if (pos > 0)
            begin
                shreg = {shreg[17:0], 1'b0};
                if (dt < {16'd0, strobe})
                begin
                    shreg[0] = 1'b1;
                    par      = ~par;
                end
                if (pos == FRAME_BITS)
                begin
                    pos = -1;
                    if (par)
                    begin
                        st = ST_PARITY;
                        return 1'b1;
                    end
                    val = {shreg[18:11], shreg[8:1]};
                    if (val != held_val || !held)
                    begin
                        held_val = val;
                        held     = 1'b1;
                        return 1'b1;
                    end
                end
            end
            return 1'b0;
        end
        // falling edge: long gap restarts, else step the bit position
        if (dt > {16'd0, gap_cfg})
            pos = 0;
        else
        begin
            if (pos == 0)
            begin
                half   = dt[31:1];
                strobe = (half > 31'(margin_cfg)) ? 16'(half - 31'(margin_cfg)) : '0;
                shreg  = '0;
                par    = 1'b0;
            end
            if (pos < POS_CEIL)
                pos++;
        end
        fall_t = t;
        return 1'b0;
    endfunction

    // Offer one edge word, optionally after an idle burst, and wait for it
    task automatic send_word(input opcode_t op, input logic [31:0] t, input logic lvl,
                             input row_check_t chk);
        frame_result_t r;
        bit            got;
        if (idle_on && $urandom_range(0, 99) < 15)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        got = decode_edge(op, t, lvl, r.st, r.val);
        if (chk == RC_MODEL && got)
            due_results.push_back(r);
        else if (chk == RC_PARITY)
        begin
            r.st  = ST_PARITY;
            r.val = '0;
            due_results.push_back(r);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        edge_time_us <= t;
        line_level   <= lvl;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_START_GAP)
            gap_cfg = data;
        else
            margin_cfg = data[MARGIN_W-1:0];
        settings_written++;
        @(posedge clk);
    endtask

    // Stop offering words and let everything due come out
    task automatic settle_block();
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Full or damaged frame: start fall, strobe fall, then one rise per bit
    task automatic send_frame(input logic [18:0] bits, input int n_bits, input int extra_falls);
        int unsigned per;
        int unsigned p_max;
        int unsigned strb;
        int unsigned low;
        int          k;
        p_max = (gap_cfg < 1500) ? 32'(gap_cfg) : 1500;
        case ($urandom_range(0, 29))
            0, 1, 2: per = p_max;
            3:       per = 32'(gap_cfg);
            default: per = $urandom_range(1, p_max);
        endcase
        strb = ((per >> 1) > margin_cfg) ? (per >> 1) - margin_cfg : 0;
        if ($urandom_range(0, 19) == 0)
            now_us = 32'hFFFF_FFFF - $urandom_range(0, 3000);
        now_us = now_us + gap_cfg + 1 + $urandom_range(0, 400);
        send_word(OP_EDGE, now_us, 1'b0, RC_MODEL);
        if ($urandom_range(0, 1))
            send_word(OP_EDGE, now_us + $urandom_range(0, per), 1'b1, RC_MODEL);
        now_us = now_us + per;
        send_word(OP_EDGE, now_us, 1'b0, RC_MODEL);
        for (k = 1; k <= n_bits; k++)
        begin
            // extra falls push the bit position past the frame length
            if (k == n_bits && extra_falls > 0)
                repeat (extra_falls)
                begin
                    now_us = now_us + per;
                    send_word(OP_EDGE, now_us, 1'b0, RC_MODEL);
                end
            if (bits[FRAME_BITS-k])
                low = (strb > 0) ? $urandom_range(0, strb - 1) : 0;
            else
                low = $urandom_range(strb, per);
            send_word(OP_EDGE, now_us + low, 1'b1, RC_MODEL);
            if (k < n_bits)
            begin
                now_us = now_us + per;
                send_word(OP_EDGE, now_us, 1'b0, RC_MODEL);
            end
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin : rx_ready_gen
        int unsigned n;
        logic        rdy;
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                rdy      = 1'b0;
                n        = HOLD_CYCLES;
            end
            else if (idle_on && $urandom_range(0, 99) < 15)
            begin
                rdy = 1'b0;
                n   = $urandom_range(1, 15);
            end
            else
            begin
                rdy = 1'b1;
                n   = $urandom_range(1, 20);
            end
            out_ready <= rdy;
            repeat (n) @(posedge clk);
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        frame_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (status == ST_PARITY)
                parity_seen++;
            if (due_results.size() == 0)
                report_mismatch("result word with nothing due",
                                {15'd0, status, sensor_value}, 0);
            else
            begin
                want = due_results.pop_front();
                if (status !== want.st)
                    report_mismatch("status", 32'(status), 32'(want.st));
                if (sensor_value !== want.val)
                    report_mismatch("sensor_value", 32'(sensor_value), 32'(want.val));
            end
        end
    end

    initial
    begin : stimulus
        edge_row_t          row;
        int unsigned        ph;
        int unsigned        phase_start;
        int unsigned        sel;
        int unsigned        k;
        int unsigned        drain_cycles;
        logic [GAP_W-1:0]   g;
        logic [7:0]         m;
        logic [VALUE_W-1:0] v;
        logic [18:0]        fb;
        bit                 drain_timeout;

        // power off and rises while waiting, zero time difference
        edge_rows.push_back('{OP_POWER_OFF, 32'hFFFF_FFFF, 1'b1, 1, 32'd0, RC_NONE});
        edge_rows.push_back('{OP_EDGE, 32'h0000_0000, 1'b1, 1, 32'd0, RC_NONE});
        edge_rows.push_back('{OP_EDGE, 32'h0000_0000, 1'b0, 1, 32'd0, RC_NONE});
        edge_rows.push_back('{OP_EDGE, 32'h0000_0005, 1'b1, 1, 32'd0, RC_NONE});
        // short first frame, first value reported
        edge_rows.push_back('{OP_EDGE, 32'h0000_0064, 1'b0, 1, 32'd0, RC_MODEL});
        edge_rows.push_back('{OP_EDGE, 32'h0000_0078, 1'b1, 1, 32'd0, RC_MODEL});
        edge_rows.push_back('{OP_EDGE, 32'h0000_00C8, 1'b0, 18, 32'd100, RC_MODEL});
        edge_rows.push_back('{OP_EDGE, 32'h0000_0776, 1'b1, 1, 32'd0, RC_MODEL});
        // frame across the timer wrap, ends with bad parity
        edge_rows.push_back('{OP_EDGE, 32'hFFFF_FF00, 1'b0, 1, 32'd0, RC_MODEL});
        edge_rows.push_back('{OP_EDGE, 32'h0000_0010, 1'b0, 1, 32'd0, RC_MODEL});
        edge_rows.push_back('{OP_EDGE, 32'h0000_001A, 1'b1, 1, 32'd0, RC_MODEL});
        edge_rows.push_back('{OP_EDGE, 32'h0000_0074, 1'b0, 18, 32'd100, RC_MODEL});
        edge_rows.push_back('{OP_EDGE, 32'h0000_07E0, 1'b1, 1, 32'd0, RC_PARITY});
        // same value again: nothing reported
        edge_rows.push_back('{OP_EDGE, 32'h0001_0000, 1'b0, 1, 32'd0, RC_MODEL});
        edge_rows.push_back('{OP_EDGE, 32'h0001_0064, 1'b0, 1, 32'd0, RC_MODEL});
        edge_rows.push_back('{OP_EDGE, 32'h0001_0078, 1'b1, 1, 32'd0, RC_MODEL});
        edge_rows.push_back('{OP_EDGE, 32'h0001_00C8, 1'b0, 18, 32'd100, RC_MODEL});
        edge_rows.push_back('{OP_EDGE, 32'h0001_0776, 1'b1, 1, 32'd0, RC_NONE});
        edge_rows.push_back('{OP_POWER_OFF, 32'h0000_0000, 1'b0, 1, 32'd0, RC_NONE});
        // strobe clamps to zero, bit position saturates
        edge_rows.push_back('{OP_EDGE, 32'h0002_0000, 1'b0, 1, 32'd0, RC_MODEL});
        edge_rows.push_back('{OP_EDGE, 32'h0002_0014, 1'b0, 1, 32'd0, RC_MODEL});
        edge_rows.push_back('{OP_EDGE, 32'h0002_0015, 1'b1, 1, 32'd0, RC_MODEL});
        edge_rows.push_back('{OP_EDGE, 32'h0002_0028, 1'b0, 35, 32'd20, RC_MODEL});
        edge_rows.push_back('{OP_EDGE, 32'h0002_02FF, 1'b1, 1, 32'd0, RC_NONE});
        edge_rows.push_back('{OP_EDGE, 32'h0002_0300, 1'b1, 1, 32'd0, RC_NONE});

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (edge_rows[i])
        begin
            row = edge_rows[i];
            for (k = 0; k < row.reps; k++)
                send_word(row.op, row.t + k * row.step, row.lvl, row.chk);
        end
        now_us = 32'h0002_0300;

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            // new register setting between phases, block idle
            if (ph != 0)
            begin
                settle_block();
                case (ph)
                    1: begin g = 16'hFFFF; m = 8'hFF; end
                    2: begin g = 16'd1;    m = 8'h00; end
                    3: begin g = 16'hFFFF; m = 8'h00; end
                    4: begin g = 16'd1;    m = 8'hFF; end
                    5: begin g = 16'($urandom_range(2, 2000));  m = 8'($urandom_range(0, 255)); end
                    6: begin g = 16'($urandom_range(1, 65535)); m = 8'($urandom_range(0, 255)); end
                    default: begin g = GAP_RESET; m = MARGIN_RESET; end
                endcase
                write_reg(CFG_START_GAP, g);
                write_reg(CFG_STROBE_MARGIN, {8'($urandom_range(0, 255)), m});
                idle_on = (ph != NUM_PHASES - 1);
                if (ph == HOLD_PHASE)
                    hold_req = 1'b1;
            end
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS)
            begin
                sel = $urandom_range(0, 99);
                v   = ($urandom_range(0, 3) == 0) ? last_sent_val : 16'($urandom());
                fb  = {v[15:8], 2'($urandom_range(0, 3)), v[7:0], 1'b0};
                fb[0] = ^fb[18:1] ^ ($urandom_range(0, 99) < 15);
                last_sent_val = v;
                if (sel < 70)
                    send_frame(fb, FRAME_BITS, 0);
                else if (sel < 82)
                    send_frame(fb, $urandom_range(0, FRAME_BITS - 1), 0);
                else if (sel < 88)
                    send_frame(fb, FRAME_BITS, $urandom_range(1, 14));
                else if (sel < 96)
                    repeat ($urandom_range(1, 6))
                    begin
                        now_us = now_us + $urandom_range(0, 50);
                        send_word(opcode_t'($urandom_range(0, 1)),
                                  $urandom_range(0, 1) ? $urandom() : now_us,
                                  1'($urandom_range(0, 1)), RC_MODEL);
                    end
                else
                    send_word(OP_POWER_OFF, $urandom(), 1'($urandom_range(0, 1)), RC_MODEL);
            end
        end

        // drain what is still due
        in_valid <= 1'b0;
        drain_cycles  = 0;
        drain_timeout = 1'b0;
        while (due_results.size() != 0 && !drain_timeout)
        begin
            @(posedge clk);
            drain_cycles++;
            drain_timeout = (drain_cycles >= DRAIN_LIMIT);
        end
        repeat (8) @(posedge clk);

        $display("Sent %0d edge words under %0d register writes across %0d phases.",
                 words_sent, settings_written, NUM_PHASES);
        $display("Checked %0d result words, %0d with a parity error; %0d mismatches.",
                 results_seen, parity_seen, mismatches);
        if (drain_timeout)
            $display("FAILURE");
        else if (mismatches == 0 && due_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin : watchdog
        #(WATCHDOG_NS);
        $display("FAILURE");
        $finish;
    end

endmodule
